/* rtl/swen_pkg.sv */
// ----------------------------------------------------------------------------
// swen_pkg
// Shared constants, codes and types of the skin weight edit block.
// ----------------------------------------------------------------------------
package swen_pkg;

  localparam int MAX_JOINTS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int TAG_W      = 16;
  localparam int MODE_W     = 3;
  localparam int TGT_W      = 5;
  localparam int COUNT_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_EDIT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = 2'd3;

  // Edit modes.
  localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_PCT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ABS     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SMOOTH  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SHARPEN = 3'd5;

  // How the back end treats a row.
  typedef enum logic [2:0] {
    KIND_EDIT    = 3'b001,
    KIND_SHARPEN = 3'b010,
    KIND_PASS    = 3'b100
  } row_kind_t;

  typedef struct packed {
    logic             bank;
    row_kind_t        kind;
    logic [TAG_W-1:0] tag;
  } row_desc_t;

endpackage

/* rtl/swen_front.sv */
// ----------------------------------------------------------------------------
// swen_front
// Accepts weights, fills one of two row banks and classifies each full row.
// ----------------------------------------------------------------------------
module swen_front #(
  parameter int MAX_JOINTS = swen_pkg::MAX_JOINTS_DEF,
  parameter int FRAC_BITS  = swen_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [FRAC_BITS:0]             in_old_weight,
  input  logic [FRAC_BITS:0]             in_strength,
  input  logic [swen_pkg::TAG_W-1:0]     in_vertex_tag,
  input  logic [$clog2(MAX_JOINTS+1)-1:0] n_eff,
  input  logic [swen_pkg::MODE_W-1:0]    edit_mode,
  input  logic [swen_pkg::TGT_W-1:0]     target_joint,
  input  logic                           row_release,
  output logic                           wr_en,
  output logic [((MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1):0] wr_addr,
  output logic [FRAC_BITS:0]             wr_data,
  output logic                           push,
  output swen_pkg::row_desc_t            push_desc,
  output logic [FRAC_BITS:0]             push_str
);

  localparam int WW   = FRAC_BITS + 1;
  localparam int CW   = $clog2(MAX_JOINTS + 1);
  localparam int JW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int CMPW = 8;
  localparam logic [WW-1:0] ONE_W = WW'(1) << FRAC_BITS;

  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       bank_r;
  logic [1:0]                 used_r, used_nxt;
  logic [WW-1:0]              str_r;
  logic [swen_pkg::TAG_W-1:0] tag_r;
  logic                       acc, first, last;
  logic [WW-1:0]              cur_str;
  logic [swen_pkg::TAG_W-1:0] cur_tag;
  swen_pkg::row_kind_t        kind;

  function automatic logic [WW-1:0] sat_one(input logic [WW-1:0] v);
    return (v > ONE_W) ? ONE_W : v;
  endfunction

  assign in_ready = (used_r != 2'd2);
  assign acc      = in_valid & in_ready;
  assign first    = (cnt_r == '0);
  assign last     = ((CW+1)'(cnt_r) + (CW+1)'(1)) >= (CW+1)'(n_eff);
  assign cur_str  = first ? sat_one(in_strength) : str_r;
  assign cur_tag  = first ? in_vertex_tag : tag_r;

  always_comb begin
    if (edit_mode == swen_pkg::MODE_SHARPEN) begin
      kind = swen_pkg::KIND_SHARPEN;
    end else if (edit_mode > swen_pkg::MODE_SHARPEN ||
                 CMPW'(target_joint) >= CMPW'(n_eff)) begin
      kind = swen_pkg::KIND_PASS;
    end else begin
      kind = swen_pkg::KIND_EDIT;
    end
  end

  assign wr_en     = acc;
  assign wr_addr   = {bank_r, cnt_r[JW-1:0]};
  assign wr_data   = sat_one(in_old_weight);
  assign push      = acc & last;
  assign push_desc = '{bank: bank_r, kind: kind, tag: cur_tag};
  assign push_str  = cur_str;

  assign cnt_nxt  = !acc ? cnt_r : (last ? '0 : cnt_r + CW'(1));
  assign used_nxt = used_r + (push ? 2'd1 : 2'd0) - (row_release ? 2'd1 : 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      bank_r <= 1'b0;
      used_r <= '0;
      str_r  <= '0;
      tag_r  <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      used_r <= used_nxt;
      if (push) begin
        bank_r <= ~bank_r;
      end
      if (acc && first) begin
        str_r <= cur_str;
        tag_r <= cur_tag;
      end
    end
  end

  // Only two banks exist, so the count of rows held can never pass two.
  assert property (@(posedge clk) disable iff (!rst_n) used_r != 2'd3)
    else $error("swen_front: more rows held than banks");

endmodule

/* rtl/swen_queue.sv */
// ----------------------------------------------------------------------------
// swen_queue
// Two-entry queue of row descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module swen_queue #(
  parameter int FRAC_BITS = swen_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  swen_pkg::row_desc_t push_desc,
  input  logic [FRAC_BITS:0]  push_str,
  input  logic                pop,
  output logic                q_valid,
  output swen_pkg::row_desc_t q_desc,
  output logic [FRAC_BITS:0]  q_str
);

  swen_pkg::row_desc_t desc_q [2];
  logic [FRAC_BITS:0]  str_q  [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r;

  assign q_valid = (cnt_r != 2'd0);
  assign q_desc  = desc_q[rp_r];
  assign q_str   = str_q[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      desc_q[wp_r] <= push_desc;
      str_q[wp_r]  <= push_str;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end
  end

endmodule

/* rtl/swen_div.sv */
// ----------------------------------------------------------------------------
// swen_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swen_div #(
  parameter int NUMW = 35,
  parameter int DENW = 23
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic            done,
  output logic [NUMW-1:0] quo
);

  localparam int CNTW = $clog2(NUMW + 1);

  logic [DENW:0]   rem_r, trial;
  logic [NUMW-1:0] quo_r;
  logic [DENW-1:0] den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r, ge;

  assign trial = {rem_r[DENW-1:0], quo_r[NUMW-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? trial - {1'b0, den_r} : trial;
      quo_r <= {quo_r[NUMW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NUMW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/swen_back.sv */
// ----------------------------------------------------------------------------
// swen_back
// Row bank memory and the sequencer that edits, reverts or normalizes a row.
// ----------------------------------------------------------------------------
module swen_back #(
  parameter int MAX_JOINTS = swen_pkg::MAX_JOINTS_DEF,
  parameter int FRAC_BITS  = swen_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [$clog2(MAX_JOINTS+1)-1:0] n_eff,
  input  logic [swen_pkg::MODE_W-1:0]    edit_mode,
  input  logic [swen_pkg::TGT_W-1:0]     target_joint,
  input  logic                           normalize_on,
  input  logic                           wr_en,
  input  logic [((MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1):0] wr_addr,
  input  logic [FRAC_BITS:0]             wr_data,
  input  logic                           q_valid,
  input  swen_pkg::row_desc_t            q_desc,
  input  logic [FRAC_BITS:0]             q_str,
  output logic                           q_pop,
  output logic                           row_release,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [FRAC_BITS:0]             out_new_weight,
  output logic [swen_pkg::TAG_W-1:0]     out_vertex_tag_out,
  output logic                           out_reverted,
  output logic                           out_row_last
);

  localparam int WW   = FRAC_BITS + 1;
  localparam int CW   = $clog2(MAX_JOINTS + 1);
  localparam int JW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int AW   = JW + 1;
  localparam int SW   = WW + CW;
  localparam int PW   = 2 * WW + 1;
  localparam int NUMW = PW;
  localparam int CMPW = 8;

  localparam longint unsigned ONE_L      = 64'd1 << FRAC_BITS;
  localparam longint unsigned HALF_L     = ONE_L / 2;
  localparam longint unsigned WMAX_L     = 2 * ONE_L - 1;
  localparam longint unsigned PASS_LIM_L = (ONE_L * 99999) / 100000;
  localparam longint unsigned REV_LIM_L  = (ONE_L + 99) / 100;

  localparam logic [WW-1:0] ONE_W  = WW'(ONE_L);
  localparam logic [WW:0]   ONE_X  = (WW+1)'(ONE_L);
  localparam logic [WW-1:0] WMAX_W = WW'(WMAX_L);

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_SUB_WAIT = 14'h0002,
    S_TGT_RD   = 14'h0004,
    S_TGT_LD   = 14'h0008,
    S_TGT_CALC = 14'h0010,
    S_P1_RD    = 14'h0020,
    S_P1_MUL   = 14'h0040,
    S_P1_VAL   = 14'h0080,
    S_P1_DIV   = 14'h0100,
    S_DECIDE   = 14'h0200,
    S_E_RD     = 14'h0400,
    S_E_VAL    = 14'h0800,
    S_E_DIV    = 14'h1000,
    S_E_OUT    = 14'h2000
  } back_state_t;

  back_state_t                state_r, state_nxt;
  logic                       bank_r, bank_nxt;
  swen_pkg::row_kind_t        kind_r, kind_nxt;
  logic [swen_pkg::TAG_W-1:0] tag_r, tag_nxt;
  logic [WW-1:0]              s_r, s_nxt;
  logic [CW-1:0]              j_r, j_nxt;
  logic [WW-1:0]              cur_r, cur_nxt;
  logic [PW-1:0]              prod_r, prod_nxt;
  logic [WW-1:0]              nw_r, nw_nxt;
  logic [WW-1:0]              orest_r, orest_nxt;
  logic [WW-1:0]              nrest_r, nrest_nxt;
  logic [WW:0]                sub_r, sub_nxt;
  logic [SW-1:0]              sum_r, sum_nxt;
  logic                       norm_r, norm_nxt;
  logic                       rev_r, rev_nxt;
  logic                       src_r, src_nxt;
  logic [WW-1:0]              outw_r, outw_nxt;
  logic                       last_r, last_nxt;

  logic [WW-1:0] buf_mem [2**AW];
  logic [WW-1:0] work_mem [2**JW];
  logic [WW-1:0] buf_rd_r, work_rd_r;
  logic [JW-1:0] rd_idx;
  logic          work_we;

  logic            div_start, div_done;
  logic [NUMW-1:0] div_num, div_quo;
  logic [SW-1:0]   div_den;

  logic          step, last_j;
  logic [WW-1:0] v, val;
  logic [WW:0]   tv, a, diff, pct, nw_raw;
  logic [PW:0]   a_full, a_sh, pct_full, pct_sh;
  logic [WW-1:0] sharp_v, nw_calc, quo_clamp;

  // Row banks and the per-row scratch copy; reads are registered.
  assign rd_idx = (state_r == S_TGT_RD) ? JW'(target_joint) : j_r[JW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= wr_data;
    end
    buf_rd_r <= buf_mem[{bank_r, rd_idx}];
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[j_r[JW-1:0]] <= v;
    end
    work_rd_r <= work_mem[j_r[JW-1:0]];
  end

  swen_div #(.NUMW(NUMW), .DENW(SW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Datapath pieces.
  assign tv       = {1'b0, s_r} + ONE_X;
  assign a_full   = {1'b0, prod_r} + (PW+1)'(HALF_L);
  assign a_sh     = a_full >> FRAC_BITS;
  assign a        = a_sh[WW:0];
  assign diff     = (a > sub_r) ? a - sub_r : '0;
  assign sharp_v  = (diff > ONE_X) ? ONE_W : diff[WW-1:0];
  assign pct_full = {1'b0, prod_r} + (PW+1)'(HALF_L);
  assign pct_sh   = pct_full >> FRAC_BITS;
  assign pct      = pct_sh[WW:0];
  assign quo_clamp = (div_quo > NUMW'(WMAX_L)) ? WMAX_W : div_quo[WW-1:0];
  assign last_j   = ((CW+1)'(j_r) + (CW+1)'(1)) == (CW+1)'(n_eff);
  assign val      = src_r ? work_rd_r : buf_rd_r;

  always_comb begin
    case (edit_mode)
      swen_pkg::MODE_ADD:     nw_raw = {1'b0, cur_r} + {1'b0, s_r};
      swen_pkg::MODE_REMOVE:  nw_raw = (cur_r > s_r) ? {1'b0, cur_r - s_r} : '0;
      swen_pkg::MODE_ADD_PCT: nw_raw = {1'b0, cur_r} + pct;
      swen_pkg::MODE_ABS:     nw_raw = {1'b0, s_r};
      default:                nw_raw = {1'b0, cur_r};
    endcase
    nw_calc = (nw_raw > ONE_X) ? ONE_W : nw_raw[WW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    bank_nxt  = bank_r;
    kind_nxt  = kind_r;
    tag_nxt   = tag_r;
    s_nxt     = s_r;
    j_nxt     = j_r;
    cur_nxt   = cur_r;
    prod_nxt  = prod_r;
    nw_nxt    = nw_r;
    orest_nxt = orest_r;
    nrest_nxt = nrest_r;
    sub_nxt   = sub_r;
    sum_nxt   = sum_r;
    norm_nxt  = norm_r;
    rev_nxt   = rev_r;
    src_nxt   = src_r;
    outw_nxt  = outw_r;
    last_nxt  = last_r;
    q_pop       = 1'b0;
    row_release = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    work_we     = 1'b0;
    step        = 1'b0;
    v           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          bank_nxt = q_desc.bank;
          kind_nxt = q_desc.kind;
          tag_nxt  = q_desc.tag;
          s_nxt    = q_str;
          j_nxt    = '0;
          sum_nxt  = '0;
          rev_nxt  = 1'b0;
          unique case (q_desc.kind)
            swen_pkg::KIND_SHARPEN: begin
              // Offset term: round((1 + s) / n).
              div_start = 1'b1;
              div_num   = NUMW'(q_str) + NUMW'(ONE_L) + NUMW'(n_eff >> 1);
              div_den   = SW'(n_eff);
              state_nxt = S_SUB_WAIT;
            end
            swen_pkg::KIND_EDIT: begin
              state_nxt = S_TGT_RD;
            end
            default: begin
              norm_nxt  = 1'b0;
              src_nxt   = 1'b0;
              state_nxt = S_E_RD;
            end
          endcase
        end
      end
      S_SUB_WAIT: begin
        if (div_done) begin
          sub_nxt   = div_quo[WW:0];
          state_nxt = S_P1_RD;
        end
      end
      S_TGT_RD: begin
        state_nxt = S_TGT_LD;
      end
      S_TGT_LD: begin
        cur_nxt   = buf_rd_r;
        prod_nxt  = PW'(s_r) * PW'(buf_rd_r);
        state_nxt = S_TGT_CALC;
      end
      S_TGT_CALC: begin
        // Remove and absolute leave a nearly full target row untouched.
        if ((edit_mode == swen_pkg::MODE_REMOVE || edit_mode == swen_pkg::MODE_ABS) &&
            cur_r > WW'(PASS_LIM_L)) begin
          norm_nxt  = 1'b0;
          src_nxt   = 1'b0;
          state_nxt = S_E_RD;
        end else begin
          nw_nxt    = nw_calc;
          orest_nxt = ONE_W - cur_r;
          nrest_nxt = ONE_W - nw_calc;
          state_nxt = S_P1_RD;
        end
      end
      S_P1_RD: begin
        state_nxt = S_P1_MUL;
      end
      S_P1_MUL: begin
        prod_nxt  = PW'(buf_rd_r) *
                    PW'((kind_r == swen_pkg::KIND_SHARPEN) ? tv : {1'b0, nrest_r});
        state_nxt = S_P1_VAL;
      end
      S_P1_VAL: begin
        if (kind_r == swen_pkg::KIND_SHARPEN) begin
          v    = sharp_v;
          step = 1'b1;
        end else if (CMPW'(j_r) == CMPW'(target_joint)) begin
          v    = nw_r;
          step = 1'b1;
        end else if (nw_r == ONE_W || orest_r == '0) begin
          v    = '0;
          step = 1'b1;
        end else begin
          div_start = 1'b1;
          div_num   = NUMW'(prod_r) + NUMW'(orest_r >> 1);
          div_den   = SW'(orest_r);
          state_nxt = S_P1_DIV;
        end
      end
      S_P1_DIV: begin
        if (div_done) begin
          v    = quo_clamp;
          step = 1'b1;
        end
      end
      S_DECIDE: begin
        j_nxt = '0;
        if (kind_r == swen_pkg::KIND_SHARPEN) begin
          src_nxt  = 1'b1;
          norm_nxt = normalize_on && sum_r != SW'(ONE_L) && sum_r != '0;
        end else if (sum_r < SW'(REV_LIM_L)) begin
          rev_nxt  = 1'b1;
          src_nxt  = 1'b0;
          norm_nxt = 1'b0;
        end else begin
          src_nxt  = 1'b1;
          norm_nxt = normalize_on && sum_r != SW'(ONE_L);
        end
        state_nxt = S_E_RD;
      end
      S_E_RD: begin
        state_nxt = S_E_VAL;
      end
      S_E_VAL: begin
        if (norm_r) begin
          div_start = 1'b1;
          div_num   = (NUMW'(val) << FRAC_BITS) + NUMW'(sum_r >> 1);
          div_den   = sum_r;
          state_nxt = S_E_DIV;
        end else begin
          outw_nxt  = val;
          last_nxt  = last_j;
          state_nxt = S_E_OUT;
        end
      end
      S_E_DIV: begin
        if (div_done) begin
          outw_nxt  = div_quo[WW-1:0];
          last_nxt  = last_j;
          state_nxt = S_E_OUT;
        end
      end
      S_E_OUT: begin
        if (out_ready) begin
          if (last_r) begin
            row_release = 1'b1;
            j_nxt       = '0;
            state_nxt   = S_IDLE;
          end else begin
            j_nxt     = j_r + CW'(1);
            state_nxt = S_E_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // One joint of the first pass is finished: store it and add it up.
    if (step) begin
      if (normalize_on && v > ONE_W) begin
        v = ONE_W;
      end
      work_we = 1'b1;
      sum_nxt = sum_r + SW'(v);
      if (last_j) begin
        j_nxt     = '0;
        state_nxt = S_DECIDE;
      end else begin
        j_nxt     = j_r + CW'(1);
        state_nxt = S_P1_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r  <= bank_nxt;
    kind_r  <= kind_nxt;
    tag_r   <= tag_nxt;
    s_r     <= s_nxt;
    cur_r   <= cur_nxt;
    prod_r  <= prod_nxt;
    nw_r    <= nw_nxt;
    orest_r <= orest_nxt;
    nrest_r <= nrest_nxt;
    sub_r   <= sub_nxt;
    sum_r   <= sum_nxt;
    norm_r  <= norm_nxt;
    rev_r   <= rev_nxt;
    src_r   <= src_nxt;
    outw_r  <= outw_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid          = (state_r == S_E_OUT);
  assign out_new_weight     = outw_r;
  assign out_vertex_tag_out = tag_r;
  assign out_reverted       = rev_r;
  assign out_row_last       = last_r;

  // A division result only arrives while the sequencer is waiting for one.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_SUB_WAIT || state_r == S_P1_DIV || state_r == S_E_DIV))
    else $error("swen_back: divider finished outside a wait state");

  // A bank goes back to the front only with the transfer of the row's last weight.
  assert property (@(posedge clk) disable iff (!rst_n)
    row_release |-> (out_valid && out_ready && out_row_last))
    else $error("swen_back: bank released before the row was delivered");

  // The joint index stays inside the row while a row is being worked on.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ((CW+1)'(j_r) < (CW+1)'(n_eff)))
    else $error("swen_back: joint index beyond row length");

endmodule

/* rtl/skin_weight_edit_normalize.sv */
// ----------------------------------------------------------------------------
// skin_weight_edit_normalize
// Edits one joint weight of a vertex row, rescales the others and
// renormalizes the row.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_ready   old_weight, strength, vertex_tag
//   out_      output     out_valid / out_ready new_weight, vertex_tag_out,
//                                              reverted, row_last
//   cfg_      input      cfg_we                cfg_idx, cfg_data
//
// Weights load at one per cycle, while a bank is free, into one of two row banks,
// so a row loads while the previous one is being processed. A row goes through an
// edit pass (skipped for pass-through rows) and then an output pass, one joint at a
// time. The shared bit-serial divider is used for each rescaled joint, for each
// joint of a normalized row and once per sharpen row.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds the back end; the front keeps loading until both
// banks are full.
// ----------------------------------------------------------------------------
module skin_weight_edit_normalize #(
  parameter int MAX_JOINTS = swen_pkg::MAX_JOINTS_DEF,
  parameter int FRAC_BITS  = swen_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [FRAC_BITS:0]                in_old_weight,
  input  logic [FRAC_BITS:0]                in_strength,
  input  logic [swen_pkg::TAG_W-1:0]        in_vertex_tag,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [FRAC_BITS:0]                out_new_weight,
  output logic [swen_pkg::TAG_W-1:0]        out_vertex_tag_out,
  output logic                              out_reverted,
  output logic                              out_row_last,
  input  logic                              cfg_we,
  input  logic [swen_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [swen_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW   = $clog2(MAX_JOINTS + 1);
  localparam int JW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int CMPW = 8;

  logic [swen_pkg::MODE_W-1:0]  mode_r;
  logic [swen_pkg::TGT_W-1:0]   target_r;
  logic [swen_pkg::COUNT_W-1:0] count_r;
  logic                         norm_on_r;
  logic [CW-1:0]                n_eff;

  logic                wr_en, push, q_pop, q_valid, row_release;
  logic [JW:0]         wr_addr;
  logic [FRAC_BITS:0]  wr_data, push_str, q_str;
  swen_pkg::row_desc_t push_desc, q_desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= swen_pkg::MODE_ADD;
      target_r  <= '0;
      count_r   <= swen_pkg::COUNT_W'(1);
      norm_on_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        swen_pkg::CFG_EDIT_MODE: mode_r    <= cfg_data[swen_pkg::MODE_W-1:0];
        swen_pkg::CFG_TARGET:    target_r  <= cfg_data[swen_pkg::TGT_W-1:0];
        swen_pkg::CFG_COUNT:     count_r   <= cfg_data[swen_pkg::COUNT_W-1:0];
        swen_pkg::CFG_NORMALIZE: norm_on_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A count of zero means one joint; counts above the row buffer size saturate.
  always_comb begin
    if (count_r == '0) begin
      n_eff = CW'(1);
    end else if (CMPW'(count_r) > CMPW'(MAX_JOINTS)) begin
      n_eff = CW'(MAX_JOINTS);
    end else begin
      n_eff = CW'(count_r);
    end
  end

  swen_front #(.MAX_JOINTS(MAX_JOINTS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_old_weight (in_old_weight),
    .in_strength   (in_strength),
    .in_vertex_tag (in_vertex_tag),
    .n_eff         (n_eff),
    .edit_mode     (mode_r),
    .target_joint  (target_r),
    .row_release   (row_release),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .push          (push),
    .push_desc     (push_desc),
    .push_str      (push_str)
  );

  swen_queue #(.FRAC_BITS(FRAC_BITS)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .push_str  (push_str),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .q_str     (q_str)
  );

  swen_back #(.MAX_JOINTS(MAX_JOINTS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .n_eff              (n_eff),
    .edit_mode          (mode_r),
    .target_joint       (target_r),
    .normalize_on       (norm_on_r),
    .wr_en              (wr_en),
    .wr_addr            (wr_addr),
    .wr_data            (wr_data),
    .q_valid            (q_valid),
    .q_desc             (q_desc),
    .q_str              (q_str),
    .q_pop              (q_pop),
    .row_release        (row_release),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_new_weight     (out_new_weight),
    .out_vertex_tag_out (out_vertex_tag_out),
    .out_reverted       (out_reverted),
    .out_row_last       (out_row_last)
  );

endmodule

/* tb/tb_skin_weight_edit_normalize.sv */
// ----------------------------------------------------------------------------
// tb_skin_weight_edit_normalize
// Streams vertex rows through the weight editor under several register
// settings and checks every emitted joint weight against a row predictor.
// ----------------------------------------------------------------------------
module tb_skin_weight_edit_normalize;

  localparam int NJ = 32;
  localparam int FB = 16;
  localparam int CIW = swen_pkg::CFG_IDX_W;
  localparam int CDW = swen_pkg::CFG_DATA_W;
  localparam longint ONE = 64'd1 << FB;
  localparam longint WMAX = 2 * ONE - 1;
  localparam int WATCHDOG = 200000;

  typedef struct packed {
    logic [FB:0]    weight;
    logic [15:0]    tag;
    logic           reverted;
    logic           last;
  } joint_res_t;

  class row_scoreboard;
    longint unsigned buf_w[NJ];
    longint unsigned cnt, strength_q;
    logic [15:0] tag_q;
    logic [2:0] mode;
    logic [4:0] target;
    logic [5:0] count;
    logic normalize;
    joint_res_t pending[$];
    int errors;

    function void reset_state();
      cnt = 0; strength_q = 0; tag_q = 0;
      mode = swen_pkg::MODE_ADD; target = 0; count = 1; normalize = 1;
      pending.delete(); errors = 0;
    endfunction

    function longint unsigned sat1(logic [FB:0] v);
      return (v > ONE) ? ONE : v;
    endfunction

    function void scale_to_one(ref longint unsigned r[NJ], input longint unsigned n,
                               input longint unsigned sum);
      for (int j = 0; j < n; j++) r[j] = (r[j] * ONE + sum / 2) / sum;
    endfunction

    function bit edit_weights(ref longint unsigned r[NJ], input longint unsigned n);
      longint unsigned sum, s, tv, sub, a, v, cur, nw, orest, nrest;
      sum = 0; s = strength_q;
      for (int j = 0; j < NJ; j++) r[j] = buf_w[j];
      if (mode == swen_pkg::MODE_SHARPEN) begin
        tv = s + ONE;
        sub = (tv + n / 2) / n;
        for (int j = 0; j < n; j++) begin
          a = (buf_w[j] * tv + ONE / 2) >> FB;
          v = (a > sub) ? a - sub : 0;
          r[j] = (v > ONE) ? ONE : v;
          sum += r[j];
        end
        if (normalize && sum != ONE && sum != 0) scale_to_one(r, n, sum);
        return 0;
      end
      if (mode > swen_pkg::MODE_SHARPEN || target >= n) return 0;
      cur = buf_w[target];
      nw = cur;
      if ((mode == swen_pkg::MODE_REMOVE || mode == swen_pkg::MODE_ABS) &&
          cur * 100000 > ONE * 99999)
        return 0;
      case (mode)
        swen_pkg::MODE_ADD: nw = cur + s;
        swen_pkg::MODE_REMOVE: nw = (cur > s) ? cur - s : 0;
        swen_pkg::MODE_ADD_PCT: nw = cur + ((s * cur + ONE / 2) >> FB);
        swen_pkg::MODE_ABS: nw = s;
        default: ;
      endcase
      if (nw > ONE) nw = ONE;
      orest = ONE - cur;
      nrest = ONE - nw;
      for (int j = 0; j < n; j++) begin
        if (j == target) v = nw;
        else if (nw == ONE || orest == 0) v = 0;
        else begin
          v = (buf_w[j] * nrest + orest / 2) / orest;
          if (v > WMAX) v = WMAX;
        end
        if (normalize && v > ONE) v = ONE;
        r[j] = v;
        sum += v;
      end
      if (sum * 100 < ONE) begin
        for (int j = 0; j < NJ; j++) r[j] = buf_w[j];
        return 1;
      end
      if (normalize && sum != ONE) scale_to_one(r, n, sum);
      return 0;
    endfunction

    function void note_input(logic [FB:0] w, logic [FB:0] st, logic [15:0] tg);
      longint unsigned n;
      longint unsigned r[NJ];
      bit rev;
      joint_res_t e;
      n = (count == 0) ? 1 : (count > NJ) ? NJ : count;
      if (cnt == 0) begin
        strength_q = sat1(st);
        tag_q = tg;
      end
      if (cnt < NJ) buf_w[cnt] = sat1(w);
      cnt++;
      if (cnt < n) return;
      cnt = 0;
      rev = edit_weights(r, n);
      for (int j = 0; j < n; j++) begin
        e.weight = r[j][FB:0];
        e.tag = tag_q;
        e.reverted = rev;
        e.last = (j + 1 == n);
        pending.push_back(e);
      end
    endfunction

    function void check_result(joint_res_t got);
      joint_res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result weight=%0d tag=%0d", got.weight, got.tag);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.weight !== e.weight) begin
        $error("new_weight expected %0d got %0d", e.weight, got.weight); errors++;
      end
      if (got.tag !== e.tag) begin
        $error("vertex_tag_out expected %0d got %0d", e.tag, got.tag); errors++;
      end
      if (got.reverted !== e.reverted) begin
        $error("reverted expected %0d got %0d", e.reverted, got.reverted); errors++;
      end
      if (got.last !== e.last) begin
        $error("row_last expected %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [FB:0] in_old_weight, in_strength;
  logic [15:0] in_vertex_tag;
  logic out_valid, out_ready;
  logic [FB:0] out_new_weight;
  logic [15:0] out_vertex_tag_out;
  logic out_reverted, out_row_last;
  logic cfg_we;
  logic [CIW-1:0] cfg_idx;
  logic [CDW-1:0] cfg_data;

  row_scoreboard sb;
  int idle_cycles;
  int items_sent;

  skin_weight_edit_normalize uut (.*);

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver side: random stalls, checks each accepted transfer.
  initial begin
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result('{out_new_weight, out_vertex_tag_out, out_reverted, out_row_last});
      out_ready <= (items_sent % 97 < 40) ? 1'b1 : (gap_len() == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_skin_weight_edit_normalize: done, errors");
      $finish;
    end
  end

  // Leaves cfg_we high; set_all drops it after its last write.
  task automatic write_reg(logic [CIW-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CDW'(value);
    @(posedge clk);
    case (idx)
      swen_pkg::CFG_EDIT_MODE: sb.mode = 3'(value);
      swen_pkg::CFG_TARGET: sb.target = 5'(value);
      swen_pkg::CFG_COUNT: sb.count = 6'(value);
      default: sb.normalize = value[0];
    endcase
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic send_weight(logic [FB:0] w, logic [FB:0] st, logic [15:0] tg);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_old_weight <= w;
    in_strength <= st;
    in_vertex_tag <= tg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(w, st, tg);
    items_sent++;
  endtask

  function automatic logic [FB:0] rand_weight();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return (FB+1)'(ONE);
    if (p == 1) return '0;
    if (p == 2) return (FB+1)'($urandom_range(ONE + 1, 2 * ONE - 1));
    if (p == 3) return (FB+1)'($urandom_range(ONE - 2, ONE));
    return (FB+1)'($urandom_range(0, ONE / 4));
  endfunction

  task automatic send_row(int n, logic [FB:0] st);
    logic [15:0] tg;
    tg = 16'($urandom);
    for (int j = 0; j < n; j++)
      send_weight(rand_weight(), (j == 0) ? st : (FB+1)'($urandom),
                  (j == 0) ? tg : 16'($urandom));
  endtask

  task automatic set_all(int m, int t, int c, int nz);
    write_reg(swen_pkg::CFG_EDIT_MODE, m);
    write_reg(swen_pkg::CFG_TARGET, t);
    write_reg(swen_pkg::CFG_COUNT, c);
    write_reg(swen_pkg::CFG_NORMALIZE, nz);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int m, c, t;
    sb = new();
    sb.reset_state();
    items_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_old_weight = '0;
    in_strength = '0;
    in_vertex_tag = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, then corner rows.
    send_weight(ONE, 2 * ONE - 1, 16'hFFFF);
    send_weight(0, 0, 0);
    in_valid <= 1'b0;
    drain();
    set_all(swen_pkg::MODE_REMOVE, 1, 3, 1);
    send_weight(ONE / 2, ONE, 16'h1234);
    send_weight(ONE, 0, 0);
    send_weight(ONE / 4, 0, 0);
    in_valid <= 1'b0;
    drain();
    // Removing everything drives the sum below the revert threshold.
    set_all(swen_pkg::MODE_REMOVE, 0, 2, 1);
    send_weight(ONE / 2, ONE, 16'h00AA);
    send_weight(100, 0, 0);
    in_valid <= 1'b0;
    drain();
    set_all(swen_pkg::MODE_ABS, 0, 2, 0);
    send_weight(ONE - 1, ONE / 3, 16'h5555);
    send_weight(ONE, 0, 0);
    in_valid <= 1'b0;
    drain();
    set_all(swen_pkg::MODE_SHARPEN, 0, 4, 1);
    send_weight(0, ONE, 16'hAAAA);
    send_weight(0, 0, 0);
    send_weight(0, 0, 0);
    send_weight(0, 0, 0);
    in_valid <= 1'b0;
    drain();
    set_all(6, 0, 0, 1);
    send_weight(ONE / 3, 0, 16'h0F0F);
    in_valid <= 1'b0;
    drain();
    set_all(swen_pkg::MODE_ADD, 31, 63, 0);
    send_row(32, ONE);
    in_valid <= 1'b0;
    drain();

    // Random part: each phase picks a setting, sends rows, then drains.
    while (items_sent < 470) begin
      m = $urandom_range(0, 9);
      m = (m > 7) ? $urandom_range(0, 5) : (m == 7 ? $urandom_range(6, 7) : m % 6);
      c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6);
      t = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31)
          : $urandom_range(0, (c > 1) ? ((c > 32) ? 31 : c - 1) : 0);
      set_all(m, t, c, $urandom_range(0, 1));
      repeat ($urandom_range(2, 5)) begin
        c = (sb.count == 0) ? 1 : (sb.count > NJ) ? NJ : sb.count;
        send_row(c, ($urandom_range(0, 3) == 0) ? (FB+1)'($urandom)
                                                : (FB+1)'($urandom_range(0, ONE)));
      end
      in_valid <= 1'b0;
      drain();
    end

    drain();
    if (sb.errors == 0) $display("tb_skin_weight_edit_normalize: done, clean");
    else $display("tb_skin_weight_edit_normalize: done, errors");
    $finish;
  end

endmodule
